### sv/opfa_pkg.sv
`timescale 1ns / 1ps

package opfa_pkg;

    // Field widths of the stream payloads and of the radius register.
    localparam int AZ_W       = 16;
    localparam int EL_W       = 14;
    localparam int COORD_W    = 24;
    localparam int RADIUS_W   = 16;

    // Packing of the slave-side tdata, lowest field first.
    localparam int AZ_LSB     = 0;
    localparam int EL_LSB     = AZ_LSB + AZ_W;
    localparam int TX_LSB     = EL_LSB + EL_W;
    localparam int TY_LSB     = TX_LSB + COORD_W;
    localparam int TZ_LSB     = TY_LSB + COORD_W;
    localparam int IN_BITS    = TZ_LSB + COORD_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // Packing of the master-side tdata, lowest field first.
    localparam int PX_LSB      = 0;
    localparam int PY_LSB      = PX_LSB + COORD_W;
    localparam int PZ_LSB      = PY_LSB + COORD_W;
    localparam int OUT_TDATA_W = PZ_LSB + COORD_W;

    // Angle handling in Q.6 degrees.
    localparam int RED_W  = 17;   // signed work width for the modulo step
    localparam int TURN_W = 15;   // reduced angle, 0 to 360 degrees
    localparam logic signed [RED_W-1:0] FULL_TURN_S    = 17'sd23040;
    localparam logic signed [RED_W-1:0] TWO_TURNS_S    = 17'sd46080;
    localparam logic signed [RED_W-1:0] HALF_TURN_S    = 17'sd11520;
    localparam logic signed [RED_W-1:0] QUARTER_TURN_S = 17'sd5760;
    localparam int Z_SCALE_SH = 10;   // Q.6 degrees to degrees * 2^16

    // CORDIC datapath widths and constants.
    localparam int CW        = 34;    // x and y, Q2.30 with headroom
    localparam int ZW        = 26;    // residual angle, degrees * 2^16
    localparam int ATAN_W    = 22;
    localparam int ATAN_LEN  = 24;
    localparam logic signed [CW-1:0] CORDIC_K  = 34'sd652032874;
    localparam logic signed [CW-1:0] ONE_CXY   = 34'sd1073741824;
    localparam logic signed [ZW-1:0] QUARTER_Z = 26'sd5898240;

    localparam logic [ATAN_W-1:0] ATAN_DEG_Q16 [ATAN_LEN] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0
    };

    // Scaling and rounding.
    localparam int TRIG_W  = 32;      // clamped sine or cosine, Q2.30
    localparam int PROD_W  = 2 * TRIG_W;
    localparam int Q30_SH  = 30;
    localparam int SCL_W   = 50;      // factor times radius plus rounding
    localparam int SUM_W   = 26;
    localparam logic signed [TRIG_W-1:0] ONE_TRIG   = 32'sd1073741824;
    localparam logic signed [SCL_W-1:0]  ROUND_Q30  = 50'sd536870912;
    localparam logic signed [SUM_W-1:0]  COORD_MAX  = 26'sd8388607;
    localparam logic signed [SUM_W-1:0]  COORD_MIN  = -26'sd8388608;
    localparam logic [RADIUS_W-1:0]      RADIUS_RESET = 16'd11520;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 neg;
    } t_lane;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_target;

endpackage

### sv/orbit_point_from_angles_core.sv
`timescale 1ns / 1ps

// Channel      | Dir | Handshake                    | Payload (lowest bits first)
// -------------+-----+------------------------------+------------------------------------------
// s_axis       | in  | s_axis_tvalid, s_axis_tready | azimuth_deg, elevation_deg, target_x/y/z
// m_axis       | out | m_axis_tvalid, m_axis_tready | point_x, point_y, point_z
// cfg          | in  | i_cfg_valid, o_cfg_ready     | orbit_radius
//
// One beat can enter every cycle while the output register is not stalled. A result passes
// through one register stage per CORDIC iteration plus the angle reduction, quadrant fold,
// sign fix, two multiplier stages and the output register.
// Reset (synchronous, active low) clears all valid bits and loads the radius with 45.0.
// When the output register is full and not taken, the whole pipeline holds in place and
// s_axis_tready drops; nothing is lost or repeated. The radius register is always ready.

module orbit_point_from_angles_core
    import opfa_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // azimuth_deg[15:0], elevation_deg[29:16], target_x[53:30], target_y[77:54],
    // target_z[101:78], zero padding[103:102]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // point_x[23:0], point_y[47:24], point_z[71:48]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,

    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [RADIUS_W-1:0]    i_cfg_data
);

    // Folds a reduced angle into [-90, 90] degrees and builds the CORDIC start vector.
    // A fold by half a turn is remembered so both outputs can be negated at the end.
    function automatic t_lane f_fold(input logic [TURN_W-1:0] a);
        logic signed [RED_W-1:0] s;
        t_lane                   l;
        s     = $signed({{(RED_W-TURN_W){1'b0}}, a});
        l.neg = 1'b0;
        if (s > HALF_TURN_S) begin
            s = s - FULL_TURN_S;
        end
        if (s > QUARTER_TURN_S) begin
            s     = s - HALF_TURN_S;
            l.neg = 1'b1;
        end else if (s < -QUARTER_TURN_S) begin
            s     = s + HALF_TURN_S;
            l.neg = 1'b1;
        end
        l.x = CORDIC_K;
        l.y = '0;
        l.z = ZW'(s) <<< Z_SCALE_SH;
        return l;
    endfunction

    // One rotation-mode CORDIC iteration; the shifts round toward minus infinity.
    function automatic t_lane f_rot(input t_lane l, input logic [ATAN_W-1:0] ang,
                                    input int sh);
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic signed [ZW-1:0] az;
        t_lane                r;
        xs = l.x >>> sh;
        ys = l.y >>> sh;
        az = $signed({{(ZW-ATAN_W){1'b0}}, ang});
        r  = l;
        if (!l.z[ZW-1]) begin
            r.x = l.x - ys;
            r.y = l.y + xs;
            r.z = l.z - az;
        end else begin
            r.x = l.x + ys;
            r.y = l.y - xs;
            r.z = l.z + az;
        end
        return r;
    endfunction

    // Applies the half-turn sign and clamps to [-1, 1] in Q2.30.
    function automatic logic signed [TRIG_W-1:0] f_trig(input logic signed [CW-1:0] v,
                                                        input logic neg);
        logic signed [CW-1:0] t;
        t = neg ? -v : v;
        if (t > ONE_CXY) begin
            return ONE_TRIG;
        end else if (t < -ONE_CXY) begin
            return -ONE_TRIG;
        end
        return TRIG_W'(t);
    endfunction

    // Rounds the scaled factor to Q.8, adds the target and saturates.
    function automatic logic signed [COORD_W-1:0] f_finish(
        input logic signed [SCL_W-1:0] p, input logic signed [COORD_W-1:0] t);
        logic signed [SCL_W-1:0] v;
        logic signed [SUM_W-1:0] s;
        v = p >>> Q30_SH;
        s = SUM_W'(v) + SUM_W'(t);
        if (s > COORD_MAX) begin
            return COORD_W'(COORD_MAX);
        end else if (s < COORD_MIN) begin
            return COORD_W'(COORD_MIN);
        end
        return COORD_W'(s);
    endfunction

    logic                        w_en;

    logic [RADIUS_W-1:0]         r_radius;

    // Reduction stage.
    logic                        r_red_vld;
    logic [TURN_W-1:0]           r_red_az;
    logic [TURN_W-1:0]           r_red_el;
    t_target                     r_red_tgt;
    logic [TURN_W-1:0]           n_red_az;
    logic [TURN_W-1:0]           n_red_el;
    t_target                     n_red_tgt;

    // CORDIC stages: index 0 holds the folded start vector, index k+1 the result of step k.
    logic [CORDIC_STEPS:0]       r_cv;
    t_lane                       r_az_c  [CORDIC_STEPS+1];
    t_lane                       r_el_c  [CORDIC_STEPS+1];
    t_target                     r_tgt_c [CORDIC_STEPS+1];
    t_lane                       n_az_c  [CORDIC_STEPS];
    t_lane                       n_el_c  [CORDIC_STEPS];

    // Sign fix and clamp.
    logic                        r_post_vld;
    logic signed [TRIG_W-1:0]    r_post_saz;
    logic signed [TRIG_W-1:0]    r_post_caz;
    logic signed [TRIG_W-1:0]    r_post_sel;
    logic signed [TRIG_W-1:0]    r_post_cel;
    t_target                     r_post_tgt;

    // First multiplier stage: direction factors in Q2.30.
    logic                        r_m1_vld;
    logic signed [TRIG_W-1:0]    r_m1_fx;
    logic signed [TRIG_W-1:0]    r_m1_fy;
    logic signed [TRIG_W-1:0]    r_m1_fz;
    t_target                     r_m1_tgt;
    logic signed [PROD_W-1:0]    n_m1_px;
    logic signed [PROD_W-1:0]    n_m1_pz;
    logic signed [PROD_W-1:0]    n_m1_sx;
    logic signed [PROD_W-1:0]    n_m1_sz;

    // Second multiplier stage: factor times radius plus half an LSB.
    logic                        r_m2_vld;
    logic signed [SCL_W-1:0]     r_m2_px;
    logic signed [SCL_W-1:0]     r_m2_py;
    logic signed [SCL_W-1:0]     r_m2_pz;
    t_target                     r_m2_tgt;
    logic signed [RADIUS_W:0]    n_m2_rad;

    // Output register.
    logic                        r_out_vld;
    logic signed [COORD_W-1:0]   r_out_x;
    logic signed [COORD_W-1:0]   r_out_y;
    logic signed [COORD_W-1:0]   r_out_z;

    // The pipeline moves as one whenever the output register can take a new beat.
    assign w_en          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_valid) begin
            r_radius <= i_cfg_data;
        end
    end

    // Azimuth modulo a full turn: the input span reaches below minus one turn, so the
    // most negative values need two turns added. Elevation only ever needs one.
    always_comb begin
        logic signed [RED_W-1:0] az;
        logic signed [RED_W-1:0] el;
        logic signed [RED_W-1:0] az_m;
        logic signed [RED_W-1:0] el_m;
        az = RED_W'($signed(s_axis_tdata[AZ_LSB +: AZ_W]));
        el = RED_W'($signed(s_axis_tdata[EL_LSB +: EL_W]));
        if (az >= FULL_TURN_S) begin
            az_m = az - FULL_TURN_S;
        end else if (az < -FULL_TURN_S) begin
            az_m = az + TWO_TURNS_S;
        end else if (az < 0) begin
            az_m = az + FULL_TURN_S;
        end else begin
            az_m = az;
        end
        if (el < 0) begin
            el_m = el + FULL_TURN_S;
        end else begin
            el_m = el;
        end
        n_red_az    = az_m[TURN_W-1:0];
        n_red_el    = el_m[TURN_W-1:0];
        n_red_tgt.x = s_axis_tdata[TX_LSB +: COORD_W];
        n_red_tgt.y = s_axis_tdata[TY_LSB +: COORD_W];
        n_red_tgt.z = s_axis_tdata[TZ_LSB +: COORD_W];
    end

    // Each iteration has its own register stage; the two angles run side by side.
    always_comb begin
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            n_az_c[k] = f_rot(r_az_c[k], ATAN_DEG_Q16[k], k);
            n_el_c[k] = f_rot(r_el_c[k], ATAN_DEG_Q16[k], k);
        end
    end

    // x uses cos(el)*sin(az), z uses -cos(el)*cos(az); both floor-shifted back to Q2.30.
    always_comb begin
        n_m1_px = r_post_cel * r_post_saz;
        n_m1_pz = r_post_cel * r_post_caz;
        n_m1_sx = n_m1_px >>> Q30_SH;
        n_m1_sz = -(n_m1_pz >>> Q30_SH);
    end

    assign n_m2_rad = $signed({1'b0, r_radius});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_vld  <= 1'b0;
            r_cv       <= '0;
            r_post_vld <= 1'b0;
            r_m1_vld   <= 1'b0;
            r_m2_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else if (w_en) begin
            r_red_vld  <= s_axis_tvalid;
            r_cv       <= {r_cv[CORDIC_STEPS-1:0], r_red_vld};
            r_post_vld <= r_cv[CORDIC_STEPS];
            r_m1_vld   <= r_post_vld;
            r_m2_vld   <= r_m1_vld;
            r_out_vld  <= r_m2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_red_az   <= n_red_az;
            r_red_el   <= n_red_el;
            r_red_tgt  <= n_red_tgt;

            r_az_c[0]  <= f_fold(r_red_az);
            r_el_c[0]  <= f_fold(r_red_el);
            r_tgt_c[0] <= r_red_tgt;
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                r_az_c[k+1]  <= n_az_c[k];
                r_el_c[k+1]  <= n_el_c[k];
                r_tgt_c[k+1] <= r_tgt_c[k];
            end

            r_post_saz <= f_trig(r_az_c[CORDIC_STEPS].y, r_az_c[CORDIC_STEPS].neg);
            r_post_caz <= f_trig(r_az_c[CORDIC_STEPS].x, r_az_c[CORDIC_STEPS].neg);
            r_post_sel <= f_trig(r_el_c[CORDIC_STEPS].y, r_el_c[CORDIC_STEPS].neg);
            r_post_cel <= f_trig(r_el_c[CORDIC_STEPS].x, r_el_c[CORDIC_STEPS].neg);
            r_post_tgt <= r_tgt_c[CORDIC_STEPS];

            r_m1_fx    <= TRIG_W'(n_m1_sx);
            r_m1_fy    <= r_post_sel;
            r_m1_fz    <= TRIG_W'(n_m1_sz);
            r_m1_tgt   <= r_post_tgt;

            r_m2_px    <= SCL_W'(r_m1_fx) * SCL_W'(n_m2_rad) + ROUND_Q30;
            r_m2_py    <= SCL_W'(r_m1_fy) * SCL_W'(n_m2_rad) + ROUND_Q30;
            r_m2_pz    <= SCL_W'(r_m1_fz) * SCL_W'(n_m2_rad) + ROUND_Q30;
            r_m2_tgt   <= r_m1_tgt;

            r_out_x    <= f_finish(r_m2_px, r_m2_tgt.x);
            r_out_y    <= f_finish(r_m2_py, r_m2_tgt.y);
            r_out_z    <= f_finish(r_m2_pz, r_m2_tgt.z);
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_z, r_out_y, r_out_x};

    // A stalled pipeline must hold every valid bit.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |=> $stable({r_red_vld, r_cv, r_post_vld, r_m1_vld, r_m2_vld}))
        else $error("pipeline valid bits moved during a stall");

    // The fold must leave the CORDIC start angle within a quarter turn.
    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cv[0] |-> (r_az_c[0].z <= QUARTER_Z) && (r_az_c[0].z >= -QUARTER_Z) &&
                    (r_el_c[0].z <= QUARTER_Z) && (r_el_c[0].z >= -QUARTER_Z))
        else $error("folded angle outside a quarter turn");

    // With the output register empty, the block never refuses an input beat.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while the output register is empty");

endmodule
